// File: hdl/ccr_pkg.sv
// Shared types, codes and helpers for the circle collision resolver.
package ccr_pkg;

  // Default number of fraction bits of the fixed point format
  localparam int CCR_FRAC_BITS = 16;

  // Result classification
  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_TRIGGER = 2'd1,
    HIT_COLLIDE = 2'd2
  } hit_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SELF_RADIUS  = 2'd0,
    CFG_SELF_TRIGGER = 2'd1,
    CFG_BOUNCE       = 2'd2,
    CFG_PUSH_OFFSET  = 2'd3
  } cfg_idx_t;

  // Request data that rides along the whole pipeline
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               body;
    logic               trig;
    logic [31:0]        min_dist;
    logic               sgnx;
    logic               sgny;
    logic [32:0]        ux;
    logic [32:0]        uy;
  } cmn_t;

  // One finished result
  typedef struct packed {
    hit_kind_t          kind;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] dvel_x;
    logic signed [31:0] dvel_y;
  } res_t;

  // Clamp a wide signed value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/circle_collision_resolve.sv
// Circle against circle overlap test and collision response pipeline.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------
//   in       | in_valid / in_ready       | positions, other radius/trigger, velocity
//   out      | out_valid / out_ready     | hit_kind, new_x/y, dvel_x/y
//   cfg      | cfg_wen (no wait)         | cfg_idx, cfg_wdata
//
// One request enters per cycle while in_ready is high, that is while the skid register is
// empty. The pipeline length is set by the 33-step square root and the FRAC_BITS+1
// step normal divider, each step one register stage, plus the multiply stages.
// Reset clears the valid bits and loads the register defaults. A stalled output
// parks one result in a skid register; the pipeline halts only while it is full.
module circle_collision_resolve #(
  parameter int FRAC_BITS = ccr_pkg::CCR_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata,
  // requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] self_x,
  input  logic signed [31:0] self_y,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic [30:0]        other_radius,
  input  logic               other_trigger,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic               has_body,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         hit_kind,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] dvel_x,
  output logic signed [31:0] dvel_y
);
  import ccr_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int DN  = F + 1;        // divider steps
  localparam int NW  = F + 2;        // signed normal component
  localparam int MW  = 35;           // push distance
  localparam int PW  = NW + MW;      // normal times push
  localparam int VW  = 32 + NW;      // velocity times normal
  localparam int SW  = VW + 1;       // dot product
  localparam int CW  = SW + NW;      // dot times normal
  localparam int LW  = 42;           // clamped projection
  localparam int EW  = LW + 19;      // projection times (1 + bounce)
  localparam logic [30:0]          PUSH_RESET = 31'(64'd1 << F);
  localparam logic signed [CW-1:0] CLIM       = CW'(64'd1 << 40);

  typedef struct packed {
    cmn_t        c;
    logic [65:0] rad;
    logic [35:0] rem;
    logic [32:0] root;
  } sq_t;

  typedef struct packed {
    cmn_t               c;
    hit_kind_t          kind;
    logic [32:0]        dlen;
    logic signed [MW-1:0] m;
    logic [34:0]        rx;
    logic [34:0]        ry;
    logic [F:0]         qx;
    logic [F:0]         qy;
  } dv_t;

  // configuration registers
  logic [30:0] self_radius;
  logic        self_trigger;
  logic [16:0] bounce_factor;
  logic [30:0] push_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_radius   <= '0;
      self_trigger  <= 1'b0;
      bounce_factor <= '0;
      push_offset   <= PUSH_RESET;
    end else if (cfg_wen) begin
      case (cfg_idx)
        CFG_SELF_RADIUS:  self_radius   <= cfg_wdata;
        CFG_SELF_TRIGGER: self_trigger  <= cfg_wdata[0];
        CFG_BOUNCE:       bounce_factor <= cfg_wdata[16:0];
        CFG_PUSH_OFFSET:  push_offset   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: halts only while the skid register holds a result
  logic adv;
  logic skid_v;
  logic out_v;
  assign adv      = !skid_v;
  assign in_ready = adv;

  // stage registers
  logic a_v, b_v, c_v;
  cmn_t a_c, b_c, c_c;
  logic signed [32:0] a_dx, a_dy;
  logic [65:0] c_sqx, c_sqy;
  sq_t  sq   [0:33];
  logic sq_v [0:33];
  dv_t  dv   [0:DN];
  logic dv_v [0:DN];

  logic m1_v, m2_v, m3_v, m4_v, m5_v, m6_v, m7_v;
  cmn_t m1_c, m2_c, m3_c, m4_c, m5_c, m6_c, m7_c;
  hit_kind_t m1_k, m2_k, m3_k, m4_k, m5_k, m6_k, m7_k;
  logic signed [MW-1:0] m1_m;
  logic signed [NW-1:0] m1_nx, m1_ny, m2_nx, m2_ny, m3_nx, m3_ny, m4_nx, m4_ny;
  logic signed [PW-1:0] m2_px, m2_py, m3_mx, m3_my;
  logic signed [VW-1:0] m2_pvx, m2_pvy;
  logic signed [SW-1:0] m3_sv, m4_s;
  logic signed [31:0]   m4_nwx, m4_nwy, m5_nwx, m5_nwy, m6_nwx, m6_nwy, m7_nwx, m7_nwy;
  logic signed [CW-1:0] m5_cx, m5_cy;
  logic signed [LW-1:0] m6_cx, m6_cy;
  logic signed [EW-1:0] m7_ex, m7_ey;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      c_v  <= 1'b0;
      sq_v[0] <= 1'b0;
      dv_v[0] <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
      m6_v <= 1'b0;
      m7_v <= 1'b0;
    end else if (adv) begin
      a_v  <= in_valid;
      b_v  <= a_v;
      c_v  <= b_v;
      sq_v[0] <= c_v;
      dv_v[0] <= sq_v[33];
      m1_v <= dv_v[DN];
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
      m6_v <= m5_v;
      m7_v <= m6_v;
    end
  end

  // common data for the first two stages
  cmn_t a_c_next, b_c_next;
  always_comb begin
    a_c_next          = '0;
    a_c_next.sx       = self_x;
    a_c_next.sy       = self_y;
    a_c_next.vx       = vel_x;
    a_c_next.vy       = vel_y;
    a_c_next.body     = has_body;
    a_c_next.trig     = self_trigger | other_trigger;
    a_c_next.min_dist = {1'b0, self_radius} + {1'b0, other_radius};

    b_c_next      = a_c;
    b_c_next.sgnx = a_dx[32];
    b_c_next.sgny = a_dy[32];
    b_c_next.ux   = a_dx[32] ? 33'(-a_dx) : 33'(a_dx);
    b_c_next.uy   = a_dy[32] ? 33'(-a_dy) : 33'(a_dy);
  end

  // front: differences, magnitudes, squares, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      a_c   <= a_c_next;
      a_dx  <= {self_x[31], self_x} - {other_x[31], other_x};
      a_dy  <= {self_y[31], self_y} - {other_y[31], other_y};

      b_c   <= b_c_next;

      c_c   <= b_c;
      c_sqx <= 66'(b_c.ux) * 66'(b_c.ux);
      c_sqy <= 66'(b_c.uy) * 66'(b_c.uy);

      sq[0].c    <= c_c;
      sq[0].rad  <= c_sqx + c_sqy;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= 33; k++) begin : g_sqrt
    localparam int I = 33 - k;
    logic [37:0] cur;
    logic [37:0] trial;
    logic        ge;
    sq_t         nxt;

    always_comb begin
      cur      = {sq[k-1].rem, sq[k-1].rad[2*I+1 -: 2]};
      trial    = {3'b000, sq[k-1].root, 2'b01};
      ge       = (cur >= trial);
      nxt      = sq[k-1];
      nxt.rem  = ge ? 36'(cur - trial) : 36'(cur);
      nxt.root = {sq[k-1].root[31:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= sq_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k] <= nxt;
      end
    end
  end

  // overlap test, classification, push distance, divider setup
  logic [32:0] e_dist;
  hit_kind_t   e_kind;
  assign e_dist = sq[33].root;

  always_comb begin
    if ({1'b0, sq[33].c.min_dist} > e_dist) begin
      e_kind = sq[33].c.trig ? HIT_TRIGGER : HIT_COLLIDE;
    end else begin
      e_kind = HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].c    <= sq[33].c;
      dv[0].kind <= e_kind;
      dv[0].dlen <= e_dist;
      dv[0].m    <= $signed({3'b000, sq[33].c.min_dist}) - $signed({2'b00, e_dist})
                    + $signed({4'b0000, push_offset});
      dv[0].rx   <= {2'b00, sq[33].c.ux};
      dv[0].ry   <= {2'b00, sq[33].c.uy};
      dv[0].qx   <= '0;
      dv[0].qy   <= '0;
    end
  end

  // normal divider: (u << F) / dist, one quotient bit per stage for each axis
  for (genvar k = 1; k <= DN; k++) begin : g_div
    logic [34:0] dd;
    logic [34:0] rnx;
    logic [34:0] rny;
    logic        gex;
    logic        gey;
    dv_t         nxt;

    always_comb begin
      dd     = {2'b00, dv[k-1].dlen};
      gex    = (dv[k-1].rx >= dd);
      gey    = (dv[k-1].ry >= dd);
      rnx    = gex ? (dv[k-1].rx - dd) : dv[k-1].rx;
      rny    = gey ? (dv[k-1].ry - dd) : dv[k-1].ry;
      nxt    = dv[k-1];
      nxt.rx = {rnx[33:0], 1'b0};
      nxt.ry = {rny[33:0], 1'b0};
      nxt.qx = {dv[k-1].qx[F-1:0], gex};
      nxt.qy = {dv[k-1].qy[F-1:0], gey};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= dv_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k] <= nxt;
      end
    end
  end

  // rounding toward zero for the arithmetic shifts
  logic signed [PW-1:0] m3_mx_next, m3_my_next;
  logic signed [SW-1:0] m3_sv_sum, m4_s_next;
  logic signed [PW:0]   m4_sumx, m4_sumy;
  logic signed [CW-1:0] m6_tx, m6_ty;
  logic signed [EW-1:0] fin_ux, fin_uy;
  logic [EW-1:0]        bias_e;

  assign m3_mx_next = (m2_px + $signed(PW'({F{m2_px[PW-1]}}))) >>> F;
  assign m3_my_next = (m2_py + $signed(PW'({F{m2_py[PW-1]}}))) >>> F;
  assign m3_sv_sum  = SW'(m2_pvx) + SW'(m2_pvy);
  assign m4_s_next  = (m3_sv + $signed(SW'({F{m3_sv[SW-1]}}))) >>> F;
  assign m4_sumx    = (PW+1)'($signed(m3_c.sx)) + (PW+1)'(m3_mx);
  assign m4_sumy    = (PW+1)'($signed(m3_c.sy)) + (PW+1)'(m3_my);
  assign m6_tx      = (m5_cx + $signed(CW'({F{m5_cx[CW-1]}}))) >>> F;
  assign m6_ty      = (m5_cy + $signed(CW'({F{m5_cy[CW-1]}}))) >>> F;
  assign bias_e     = EW'(16'hFFFF);
  assign fin_ux     = (m7_ex + (m7_ex[EW-1] ? $signed(bias_e) : $signed(EW'(0)))) >>> 16;
  assign fin_uy     = (m7_ey + (m7_ey[EW-1] ? $signed(bias_e) : $signed(EW'(0)))) >>> 16;

  // clamp of the projection to +/- 2^40
  function automatic logic signed [LW-1:0] clamp40(input logic signed [CW-1:0] t);
    logic signed [LW-1:0] r;
    if (t > CLIM) begin
      r = LW'(CLIM);
    end else if (t < -CLIM) begin
      r = LW'(-CLIM);
    end else begin
      r = LW'(t);
    end
    return r;
  endfunction

  // back end: signed normal, products, push-out, velocity response
  always_ff @(posedge clk) begin
    if (adv) begin
      // signed normal, zero for coincident centres
      m1_c  <= dv[DN].c;
      m1_k  <= dv[DN].kind;
      m1_m  <= dv[DN].m;
      if (dv[DN].dlen == '0) begin
        m1_nx <= '0;
        m1_ny <= '0;
      end else begin
        m1_nx <= dv[DN].c.sgnx ? -$signed({1'b0, dv[DN].qx}) : $signed({1'b0, dv[DN].qx});
        m1_ny <= dv[DN].c.sgny ? -$signed({1'b0, dv[DN].qy}) : $signed({1'b0, dv[DN].qy});
      end

      // products
      m2_c   <= m1_c;
      m2_k   <= m1_k;
      m2_nx  <= m1_nx;
      m2_ny  <= m1_ny;
      m2_px  <= PW'(m1_nx) * PW'(m1_m);
      m2_py  <= PW'(m1_ny) * PW'(m1_m);
      m2_pvx <= VW'(m1_nx) * VW'($signed(m1_c.vx));
      m2_pvy <= VW'(m1_ny) * VW'($signed(m1_c.vy));

      // shifted push, dot product
      m3_c  <= m2_c;
      m3_k  <= m2_k;
      m3_nx <= m2_nx;
      m3_ny <= m2_ny;
      m3_mx <= m3_mx_next;
      m3_my <= m3_my_next;
      m3_sv <= m3_sv_sum;

      // new position, projected speed
      m4_c  <= m3_c;
      m4_k  <= m3_k;
      m4_nx <= m3_nx;
      m4_ny <= m3_ny;
      m4_s  <= m4_s_next;
      m4_nwx <= (m3_k == HIT_COLLIDE) ? sat32(64'(m4_sumx)) : m3_c.sx;
      m4_nwy <= (m3_k == HIT_COLLIDE) ? sat32(64'(m4_sumy)) : m3_c.sy;

      // projection onto the normal
      m5_c   <= m4_c;
      m5_k   <= m4_k;
      m5_nwx <= m4_nwx;
      m5_nwy <= m4_nwy;
      m5_cx  <= CW'(m4_s) * CW'(m4_nx);
      m5_cy  <= CW'(m4_s) * CW'(m4_ny);

      // shift and clamp
      m6_c   <= m5_c;
      m6_k   <= m5_k;
      m6_nwx <= m5_nwx;
      m6_nwy <= m5_nwy;
      m6_cx  <= clamp40(m6_tx);
      m6_cy  <= clamp40(m6_ty);

      // scale by one plus bounce (18 bit unsigned factor)
      m7_c   <= m6_c;
      m7_k   <= m6_k;
      m7_nwx <= m6_nwx;
      m7_nwy <= m6_nwy;
      m7_ex  <= EW'(m6_cx) * EW'($signed({1'b0, 18'(18'd65536 + {1'b0, bounce_factor})}));
      m7_ey  <= EW'(m6_cy) * EW'($signed({1'b0, 18'(18'd65536 + {1'b0, bounce_factor})}));
    end
  end

  // finished result
  res_t res;
  always_comb begin
    res.kind  = m7_k;
    res.new_x = m7_nwx;
    res.new_y = m7_nwy;
    if (m7_k == HIT_COLLIDE && m7_c.body) begin
      res.dvel_x = sat32(64'(-fin_ux));
      res.dvel_y = sat32(64'(-fin_uy));
    end else begin
      res.dvel_x = '0;
      res.dvel_y = '0;
    end
  end

  // output register with skid
  res_t out_r;
  res_t skid_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && out_ready) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else if (!m7_v) begin
        out_v <= 1'b0;
      end
    end else if (!out_v) begin
      out_v <= m7_v;
    end else if (m7_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && out_ready) begin
      if (skid_v) begin
        out_r <= skid_r;
      end else if (m7_v) begin
        out_r <= res;
      end
    end else if (!out_v) begin
      if (m7_v) begin
        out_r <= res;
      end
    end else if (adv && m7_v) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v;
  assign hit_kind  = out_r.kind;
  assign new_x     = out_r.new_x;
  assign new_y     = out_r.new_y;
  assign dvel_x    = out_r.dvel_x;
  assign dvel_y    = out_r.dvel_y;

endmodule
